// File: hw/rtl/line_line_intersection_macros.svh
// ----------------------------------------------------------------------------
// line_line_intersection_macros.svh
// Assertion macros shared by the intersection block.
// ----------------------------------------------------------------------------
`ifndef LINE_LINE_INTERSECTION_MACROS_SVH
`define LINE_LINE_INTERSECTION_MACROS_SVH

// Implication in the same cycle, disabled during reset
`define LLI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication in the next cycle, disabled during reset
`define LLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/lli_pkg.sv
// ----------------------------------------------------------------------------
// lli_pkg
// Shared types for the line intersection pipeline.
// ----------------------------------------------------------------------------
package lli_pkg;

	// Sideband that travels alongside each item through the divider chain
	typedef struct packed {
		logic vld;
		logic neg_x;
		logic neg_y;
		logic par;
	} lli_side_t;

endpackage

// File: hw/rtl/lli_front.sv
// ----------------------------------------------------------------------------
// lli_front
// Line coefficients, determinant and Cramer numerators, then magnitudes.
// Six register stages, multiplies split to at most (W+1) x (W+1).
// ----------------------------------------------------------------------------
module lli_front
	import lli_pkg::*;
#(
	parameter int W = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic [8*W-1:0]        pts,
	output lli_side_t             side,
	output logic [3*W+2:0]        rem_x,
	output logic [3*W+2:0]        rem_y,
	output logic [2*W+2:0]        den
);

	localparam int PW = 3 * W + 2;
	localparam int NW = 3 * W + 3;
	localparam int DW = 2 * W + 3;

	logic signed [W-1:0] x1, y1, x2, y2, x3, y3, x4, y4;

	logic                  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [W:0]     a1_s1, b1_s1, a2_s1, b2_s1;
	logic signed [2*W-1:0] p21_s1, p12_s1, p43_s1, p34_s1;
	logic signed [W:0]     a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [2*W:0]   c1_s2, c2_s2;
	logic signed [2*W+1:0] m1_s2, m2_s2;
	logic signed [W:0]     c1l, c2l;
	logic signed [W:0]     c1h, c2h;
	logic signed [DW-1:0]  det_s3;
	logic signed [2*W+1:0] bc2h_s3, bc2l_s3, bc1h_s3, bc1l_s3;
	logic signed [2*W+1:0] ca2h_s3, ca2l_s3, ca1h_s3, ca1l_s3;
	logic signed [DW-1:0]  det_s4;
	logic signed [PW-1:0]  tb1c2_s4, tb2c1_s4, tc1a2_s4, tc2a1_s4;
	logic signed [DW-1:0]  det_s5;
	logic signed [NW-1:0]  nx_s5, ny_s5;

	assign x1 = pts[0*W +: W];
	assign y1 = pts[1*W +: W];
	assign x2 = pts[2*W +: W];
	assign y2 = pts[3*W +: W];
	assign x3 = pts[4*W +: W];
	assign y3 = pts[5*W +: W];
	assign x4 = pts[6*W +: W];
	assign y4 = pts[7*W +: W];

	// c split into an unsigned low word and a signed high part
	assign c1l = $signed({1'b0, c1_s2[W-1:0]});
	assign c2l = $signed({1'b0, c2_s2[W-1:0]});
	assign c1h = c1_s2[2*W:W];
	assign c2h = c2_s2[2*W:W];

	// Valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			side   <= '0;
		end else if (en) begin
			vld_s1     <= in_vld;
			vld_s2     <= vld_s1;
			vld_s3     <= vld_s2;
			vld_s4     <= vld_s3;
			vld_s5     <= vld_s4;
			side.vld   <= vld_s5;
			side.neg_x <= nx_s5[NW-1] ^ det_s5[DW-1];
			side.neg_y <= ny_s5[NW-1] ^ det_s5[DW-1];
			side.par   <= (det_s5 == '0);
		end
	end

	// Arithmetic stages
	always_ff @(posedge clk) begin
		if (en) begin
			// s1: direction terms and point cross products
			a1_s1  <= (W+1)'(y2) - (W+1)'(y1);
			b1_s1  <= (W+1)'(x1) - (W+1)'(x2);
			a2_s1  <= (W+1)'(y4) - (W+1)'(y3);
			b2_s1  <= (W+1)'(x3) - (W+1)'(x4);
			p21_s1 <= (2*W)'(x2) * (2*W)'(y1);
			p12_s1 <= (2*W)'(x1) * (2*W)'(y2);
			p43_s1 <= (2*W)'(x4) * (2*W)'(y3);
			p34_s1 <= (2*W)'(x3) * (2*W)'(y4);
			// s2: c terms and determinant products
			a1_s2 <= a1_s1;
			b1_s2 <= b1_s1;
			a2_s2 <= a2_s1;
			b2_s2 <= b2_s1;
			c1_s2 <= (2*W+1)'(p21_s1) - (2*W+1)'(p12_s1);
			c2_s2 <= (2*W+1)'(p43_s1) - (2*W+1)'(p34_s1);
			m1_s2 <= (2*W+2)'(a1_s1) * (2*W+2)'(b2_s1);
			m2_s2 <= (2*W+2)'(a2_s1) * (2*W+2)'(b1_s1);
			// s3: determinant and partial numerator products
			det_s3  <= DW'(m1_s2) - DW'(m2_s2);
			bc2h_s3 <= (2*W+2)'(b1_s2) * (2*W+2)'(c2h);
			bc2l_s3 <= (2*W+2)'(b1_s2) * (2*W+2)'(c2l);
			bc1h_s3 <= (2*W+2)'(b2_s2) * (2*W+2)'(c1h);
			bc1l_s3 <= (2*W+2)'(b2_s2) * (2*W+2)'(c1l);
			ca2h_s3 <= (2*W+2)'(c1h) * (2*W+2)'(a2_s2);
			ca2l_s3 <= (2*W+2)'(c1l) * (2*W+2)'(a2_s2);
			ca1h_s3 <= (2*W+2)'(c2h) * (2*W+2)'(a1_s2);
			ca1l_s3 <= (2*W+2)'(c2l) * (2*W+2)'(a1_s2);
			// s4: recombine partial products
			det_s4   <= det_s3;
			tb1c2_s4 <= (PW'(bc2h_s3) <<< W) + PW'(bc2l_s3);
			tb2c1_s4 <= (PW'(bc1h_s3) <<< W) + PW'(bc1l_s3);
			tc1a2_s4 <= (PW'(ca2h_s3) <<< W) + PW'(ca2l_s3);
			tc2a1_s4 <= (PW'(ca1h_s3) <<< W) + PW'(ca1l_s3);
			// s5: numerators
			det_s5 <= det_s4;
			nx_s5  <= NW'(tb1c2_s4) - NW'(tb2c1_s4);
			ny_s5  <= NW'(tc1a2_s4) - NW'(tc2a1_s4);
			// s6: magnitudes for the divider
			rem_x <= nx_s5[NW-1] ? NW'(-nx_s5) : NW'(nx_s5);
			rem_y <= ny_s5[NW-1] ? NW'(-ny_s5) : NW'(ny_s5);
			den   <= det_s5[DW-1] ? DW'(-det_s5) : DW'(det_s5);
		end
	end

endmodule

// File: hw/rtl/lli_div_cell.sv
// ----------------------------------------------------------------------------
// lli_div_cell
// One restoring division step for both coordinates against a shared divisor.
// Decides quotient bit SHIFT and hands remainder and divisor on.
// ----------------------------------------------------------------------------
module lli_div_cell
	import lli_pkg::*;
#(
	parameter int NUM_W = 99,
	parameter int DEN_W = 67,
	parameter int Q_W   = 33,
	parameter int SHIFT = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  lli_side_t        side_i,
	input  logic [NUM_W-1:0] rem_x_i,
	input  logic [NUM_W-1:0] rem_y_i,
	input  logic [DEN_W-1:0] den_i,
	input  logic [Q_W-1:0]   q_x_i,
	input  logic [Q_W-1:0]   q_y_i,
	output lli_side_t        side_o,
	output logic [NUM_W-1:0] rem_x_o,
	output logic [NUM_W-1:0] rem_y_o,
	output logic [DEN_W-1:0] den_o,
	output logic [Q_W-1:0]   q_x_o,
	output logic [Q_W-1:0]   q_y_o
);

	logic [NUM_W:0] dsh;
	logic           ge_x, ge_y;

	// Divisor aligned to this bit, then trial compare
	assign dsh  = (NUM_W+1)'(den_i) << SHIFT;
	assign ge_x = {1'b0, rem_x_i} >= dsh;
	assign ge_y = {1'b0, rem_y_i} >= dsh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_o <= '0;
		end else if (en) begin
			side_o <= side_i;
		end
	end

	// Bit SHIFT of the incoming quotient is still clear, so OR it in
	always_ff @(posedge clk) begin
		if (en) begin
			rem_x_o <= ge_x ? rem_x_i - dsh[NUM_W-1:0] : rem_x_i;
			rem_y_o <= ge_y ? rem_y_i - dsh[NUM_W-1:0] : rem_y_i;
			den_o   <= den_i;
			q_x_o   <= q_x_i | (Q_W'(ge_x) << SHIFT);
			q_y_o   <= q_y_i | (Q_W'(ge_y) << SHIFT);
		end
	end

endmodule

// File: hw/rtl/line_line_intersection.sv
// Throughput: one item per cycle; the whole pipeline holds while the output
// register is full and not taken, so input readiness follows the output side.
// The quotient comes from a chain of COORD_WIDTH + 1 restoring divider cells.
// Reset (arst_n low, asynchronous) empties every stage; no clearing pass.
// ----------------------------------------------------------------------------
// line_line_intersection
// Crossing point of two lines given by point pairs, by Cramer's rule, with
// truncating division, saturation and a parallel flag.
// ----------------------------------------------------------------------------
module line_line_intersection
	import lli_pkg::*;
#(
	parameter int COORD_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// first_x, first_y, second_x, second_y, third_x, third_y, fourth_x, fourth_y
	input  logic [((8*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// cross_x, cross_y
	output logic [((2*COORD_WIDTH+7)/8)*8-1:0]   m_tdata,
	// parallel, saturated
	output logic [1:0]                           m_tuser
);

	`include "line_line_intersection_macros.svh"

	localparam int W      = COORD_WIDTH;
	localparam int NW     = 3 * W + 3;
	localparam int DW     = 2 * W + 3;
	localparam int QW     = W + 1;
	localparam int NCELL  = W + 1;
	localparam int OUT_DW = ((2 * W + 7) / 8) * 8;

	logic            en;
	logic            out_vld_q;
	logic [W-1:0]    x_q, y_q;
	logic            par_q, sat_q;

	lli_side_t       side [NCELL+1];
	logic [NW-1:0]   rem_x [NCELL+1];
	logic [NW-1:0]   rem_y [NCELL+1];
	logic [DW-1:0]   den [NCELL+1];
	logic [QW-1:0]   q_x [NCELL+1];
	logic [QW-1:0]   q_y [NCELL+1];

	logic [W-1:0]    lim_x, lim_y, mag_x, mag_y;
	logic            sat_x, sat_y;
	lli_side_t       fin;

	// Global advance: the output register is empty or being taken
	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	lli_front #(.W(W)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (s_tvalid),
		.pts    (s_tdata[8*W-1:0]),
		.side   (side[0]),
		.rem_x  (rem_x[0]),
		.rem_y  (rem_y[0]),
		.den    (den[0])
	);

	assign q_x[0] = '0;
	assign q_y[0] = '0;

	// Divider chain, most significant quotient bit first
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		lli_div_cell #(
			.NUM_W (NW),
			.DEN_W (DW),
			.Q_W   (QW),
			.SHIFT (W - i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.side_i  (side[i]),
			.rem_x_i (rem_x[i]),
			.rem_y_i (rem_y[i]),
			.den_i   (den[i]),
			.q_x_i   (q_x[i]),
			.q_y_i   (q_y[i]),
			.side_o  (side[i+1]),
			.rem_x_o (rem_x[i+1]),
			.rem_y_o (rem_y[i+1]),
			.den_o   (den[i+1]),
			.q_x_o   (q_x[i+1]),
			.q_y_o   (q_y[i+1])
		);
	end

	// Clamp to the signed range; the negative end is one further out
	assign fin   = side[NCELL];
	assign lim_x = {1'b0, {(W-1){1'b1}}} + W'(fin.neg_x);
	assign lim_y = {1'b0, {(W-1){1'b1}}} + W'(fin.neg_y);
	assign sat_x = q_x[NCELL][W] || (q_x[NCELL][W-1:0] > lim_x);
	assign sat_y = q_y[NCELL][W] || (q_y[NCELL][W-1:0] > lim_y);
	assign mag_x = sat_x ? lim_x : q_x[NCELL][W-1:0];
	assign mag_y = sat_y ? lim_y : q_y[NCELL][W-1:0];

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= fin.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (fin.par) begin
				x_q   <= '0;
				y_q   <= '0;
				par_q <= 1'b1;
				sat_q <= 1'b0;
			end else begin
				x_q   <= fin.neg_x ? W'(-mag_x) : mag_x;
				y_q   <= fin.neg_y ? W'(-mag_y) : mag_y;
				par_q <= 1'b0;
				sat_q <= sat_x || sat_y;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_DW'({y_q, x_q});
	assign m_tuser  = {sat_q, par_q};

	// Checks
	`LLI_ASSERT_NOW(a_par_zero, clk, arst_n, m_tvalid && m_tuser[0], (x_q == '0) && (y_q == '0) && !m_tuser[1], "parallel result not zero")
	`LLI_ASSERT_NOW(a_sat_end, clk, arst_n, m_tvalid && m_tuser[1], (x_q == {1'b0, {(W-1){1'b1}}}) || (x_q == {1'b1, {(W-1){1'b0}}}) || (y_q == {1'b0, {(W-1){1'b1}}}) || (y_q == {1'b1, {(W-1){1'b0}}}), "saturated without a clamped coordinate")
	`LLI_ASSERT_NOW(a_stall_full, clk, arst_n, !s_tready, m_tvalid && !m_tready, "input held without a waiting result")
	`LLI_ASSERT_NEXT(a_hold_full, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "waiting result changed")

endmodule

// File: tb/sv/line_line_intersection_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_line_intersection_tb
// Streams point quadruples into the intersection block and checks each
// crossing point, parallel flag and saturation flag against a wide-integer
// Cramer's rule predictor. Both stream sides idle at random in the first two
// of three phases, and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module line_line_intersection_tb;

	localparam int CW = 32;
	localparam int LATENCY = CW + 8;
	localparam int N_RANDOM = 1730;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [CW-1:0] pt [8];
	} quad_t;

	typedef struct {
		logic [CW-1:0] cx;
		logic [CW-1:0] cy;
		logic          par;
		logic          sat;
	} cross_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [8*CW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [2*CW-1:0] m_tdata;
	logic [1:0] m_tuser;

	quad_t  pending_quads [$];
	cross_t expected_crossings [$];
	int     mismatches = 0;
	int     phase = 0;
	int     hold_off = 0;
	bit     hold_done = 0;
	bit     stim_done = 0;
	longint cycles = 0;

	line_line_intersection #(.COORD_WIDTH(CW)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	// Truncating quotient clamped to the coordinate range
	function automatic logic [CW-1:0] clamp_quot(logic signed [191:0] num,
			logic signed [191:0] den, inout logic sat);
		logic signed [191:0] q;
		logic signed [191:0] hi;
		logic signed [191:0] lo;
		q = num / den;
		hi = (192'sd1 <<< (CW-1)) - 1;
		lo = -(192'sd1 <<< (CW-1));
		if (q > hi) begin
			sat = 1'b1;
			q = hi;
		end else if (q < lo) begin
			sat = 1'b1;
			q = lo;
		end
		return q[CW-1:0];
	endfunction

	function automatic cross_t predict_crossing(quad_t q);
		logic signed [191:0] p [8];
		logic signed [191:0] a1, b1, a2, b2, c1, c2, det, nx, ny;
		cross_t r;
		for (int i = 0; i < 8; i++) p[i] = q.pt[i];
		a1 = p[3] - p[1];
		b1 = p[0] - p[2];
		a2 = p[7] - p[5];
		b2 = p[4] - p[6];
		c1 = p[2] * p[1] - p[0] * p[3];
		c2 = p[6] * p[5] - p[4] * p[7];
		det = a1 * b2 - a2 * b1;
		r.sat = 1'b0;
		if (det == 0) begin
			r.cx = '0;
			r.cy = '0;
			r.par = 1'b1;
			return r;
		end
		nx = b1 * c2 - b2 * c1;
		ny = c1 * a2 - c2 * a1;
		r.par = 1'b0;
		r.cx = clamp_quot(nx, det, r.sat);
		r.cy = clamp_quot(ny, det, r.sat);
		return r;
	endfunction

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return {$urandom} % 32'h0040_0000 - 32'h0020_0000;
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
		endcase
	endfunction

	function automatic quad_t make_quad(logic [CW-1:0] v [8]);
		quad_t q;
		for (int i = 0; i < 8; i++) q.pt[i] = v[i];
		return q;
	endfunction

	initial begin
		logic [CW-1:0] v [8];
		// Directed: axis lines, horizontal line one, parallels, equal points, extremes
		v = '{0, 0, 32'h10000, 0, 0, 32'hFFFF0000, 0, 32'h10000};  pending_quads.push_back(make_quad(v));
		v = '{0, 32'h20000, 32'h10000, 32'h20000, 32'h30000, 0, 32'h30000, 32'h10000};
		pending_quads.push_back(make_quad(v));
		v = '{0, 0, 32'h10000, 32'h10000, 0, 32'h10000, 32'h10000, 32'h20000};
		pending_quads.push_back(make_quad(v));
		v = '{5, 7, 5, 7, 0, 0, 32'h10000, 32'h10000};  pending_quads.push_back(make_quad(v));
		v = '{0, 0, 0, 0, 0, 0, 0, 0};  pending_quads.push_back(make_quad(v));
		v = '{32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF};
		pending_quads.push_back(make_quad(v));
		v = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
		pending_quads.push_back(make_quad(v));
		// nearly parallel lines push the crossing out of range
		v = '{0, 0, 32'h7FFF0000, 32'h10000, 0, 1, 32'h7FFF0000, 32'h10002};
		pending_quads.push_back(make_quad(v));
		v = '{0, 0, 32'h80000000, 32'h10000, 0, 1, 32'h80000000, 32'h10002};
		pending_quads.push_back(make_quad(v));
		v = '{1, 0, 0, 1, 32'h7FFFFFFF, 0, 32'h80000000, 0};  pending_quads.push_back(make_quad(v));
		for (int k = 0; k < N_RANDOM; k++) begin
			for (int i = 0; i < 8; i++) v[i] = rand_coord();
			// some share a direction to provoke parallels and saturation
			if ($urandom_range(0, 9) == 0) begin
				v[6] = v[4] + (v[2] - v[0]);
				v[7] = v[5] + (v[3] - v[1]) + $urandom_range(0, 2);
			end
			pending_quads.push_back(make_quad(v));
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver
	always @(posedge clk) begin
		quad_t q;
		int idle_pct;
		idle_pct = (phase == 0) ? 36 : (phase == 1) ? 84 : 0;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				void'(pending_quads.pop_front());
			if ((!s_tvalid || s_tready) && pending_quads.size() > 0 &&
					$urandom_range(0, 99) >= idle_pct) begin
				q = pending_quads[0];
				s_tvalid <= 1'b1;
				for (int i = 0; i < 8; i++) s_tdata[i*CW +: CW] <= q.pt[i];
			end else if (!s_tvalid || s_tready) begin
				s_tvalid <= 1'b0;
			end
			if (s_tvalid && s_tready)
				expected_crossings.push_back(predict_crossing(
					make_quad('{s_tdata[0+:CW], s_tdata[CW+:CW], s_tdata[2*CW+:CW],
					s_tdata[3*CW+:CW], s_tdata[4*CW+:CW], s_tdata[5*CW+:CW],
					s_tdata[6*CW+:CW], s_tdata[7*CW+:CW]})));
		end
	end

	// Long receiver hold-off, counted in its own process
	always @(posedge clk) begin
		if (arst_n && !hold_done && pending_quads.size() < 1200 && hold_off == 0)
			hold_off <= 300;
		else if (hold_off > 1) hold_off <= hold_off - 1;
		else if (hold_off == 1) begin
			hold_off <= 0;
			hold_done <= 1;
		end
	end

	// Monitor
	always @(posedge clk) begin
		int idle_pct;
		cross_t e;
		idle_pct = (phase == 0) ? 84 : (phase == 1) ? 36 : 0;
		cycles <= cycles + 1;
		if (arst_n) begin
			m_tready <= (hold_off == 0) && ($urandom_range(0, 99) >= idle_pct);
			if (pending_quads.size() < 580) phase <= 2;
			else if (pending_quads.size() < 1150) phase <= 1;
			if (m_tvalid && m_tready) begin
				if (expected_crossings.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected transfer %h %b", m_tdata, m_tuser);
				end else begin
					e = expected_crossings.pop_front();
					if (m_tdata[CW-1:0] !== e.cx || m_tdata[2*CW-1:CW] !== e.cy ||
							m_tuser[0] !== e.par || m_tuser[1] !== e.sat) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp x=%h y=%h par=%b sat=%b, got x=%h y=%h par=%b sat=%b",
								e.cx, e.cy, e.par, e.sat, m_tdata[CW-1:0], m_tdata[2*CW-1:CW],
								m_tuser[0], m_tuser[1]);
					end
				end
			end
		end
	end

	// End of run
	initial begin
		wait (arst_n);
		wait (pending_quads.size() == 0 && !s_tvalid && expected_crossings.size() == 0);
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatches == 0 && expected_crossings.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
